>>> design/rkm_pkg.sv
// rkm_pkg: shared constants, types and helper functions of the rabin-karp matcher
// depends on nothing; used by every module of the block
package rkm_pkg;

  localparam int unsigned MaxPattern = 64;
  localparam int unsigned AddrW      = $clog2(MaxPattern);
  localparam int unsigned LenW       = $clog2(MaxPattern + 1);
  localparam int unsigned HashW      = 31;
  localparam int unsigned WordW      = 32;
  localparam int unsigned OutW       = 136;

  localparam logic [1:0] ActClearPat   = 2'd0;
  localparam logic [1:0] ActAppend     = 2'd1;
  localparam logic [1:0] ActText       = 2'd2;
  localparam logic [1:0] ActClearStats = 2'd3;

  localparam logic [0:0] RegBase    = 1'b0;
  localparam logic [0:0] RegModulus = 1'b1;

  localparam logic [WordW-1:0] ModMin = 32'd2;
  localparam logic [WordW-1:0] ModMax = 32'h8000_0000;

  // request to the modular multiplier
  typedef struct packed {
    logic             start;
    logic             short_op;  // multiplier is a byte
    logic [HashW-1:0] a;         // multiplicand, below the modulus
    logic [WordW-1:0] q;         // multiplier bits
  } mm_req_t;

  typedef struct packed {
    logic             done;
    logic [HashW-1:0] res;
  } mm_rsp_t;

  function automatic logic [WordW-1:0] sat_inc(input logic [WordW-1:0] v);
    sat_inc = (v == '1) ? v : v + 32'd1;
  endfunction

  // x + y mod m, both below m
  function automatic logic [HashW-1:0] add_mod(input logic [HashW-1:0] x,
                                               input logic [HashW-1:0] y,
                                               input logic [WordW-1:0] m);
    logic [WordW-1:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= m) s = s - m;
    add_mod = s[HashW-1:0];
  endfunction

  // x - y mod m, both below m
  function automatic logic [HashW-1:0] sub_mod(input logic [HashW-1:0] x,
                                               input logic [HashW-1:0] y,
                                               input logic [WordW-1:0] m);
    logic [WordW-1:0] s;
    if (x >= y) s = {1'b0, x} - {1'b0, y};
    else        s = {1'b0, x} + m - {1'b0, y};
    sub_mod = s[HashW-1:0];
  endfunction

endpackage

>>> design/rkm_modmul.sv
// rkm_modmul: bit-serial interleaved modular multiplier, one multiplier bit per cycle
// depends on rkm_pkg
module rkm_modmul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [rkm_pkg::WordW-1:0]     modulus_i,
  input  rkm_pkg::mm_req_t              req_i,
  output rkm_pkg::mm_rsp_t              rsp_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [5:0]                   cnt_q;
  logic [rkm_pkg::WordW-1:0]    r_q, r_d;
  logic [rkm_pkg::WordW-1:0]    q_q;
  logic [rkm_pkg::HashW-1:0]    a_q;

  // r = 2r mod m, then r = r + a mod m when the bit is set
  always_comb begin
    logic [rkm_pkg::WordW:0] t;
    t = {r_q, 1'b0};
    if (t >= {1'b0, modulus_i}) t = t - {1'b0, modulus_i};
    if (q_q[rkm_pkg::WordW-1]) begin
      t = t + {2'b0, a_q};
      if (t >= {1'b0, modulus_i}) t = t - {1'b0, modulus_i};
    end
    r_d = t[rkm_pkg::WordW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.short_op ? 6'd8 : 6'd32;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= '0;
      a_q <= req_i.a;
      q_q <= req_i.short_op ? {req_i.q[7:0], 24'd0} : req_i.q;
    end else if (busy_q) begin
      r_q <= r_d;
      q_q <= {q_q[rkm_pkg::WordW-2:0], 1'b0};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = r_q[rkm_pkg::HashW-1:0];

endmodule

>>> design/rabin_karp_matcher.sv
// rabin_karp_matcher: top level with sequencer, pattern and window memories, statistics
// depends on rkm_pkg and rkm_modmul
//
// usage
//  - input stream: tuser carries the action (clear pattern, append pattern byte,
//    text byte, clear statistics), tdata the byte; one beat per item
//  - output stream: one result beat per input beat, in order
//  - config channel: index 0 hash base, 1 hash modulus; a write clears the
//    pattern and restarts the text, statistics are kept; write only when idle;
//    a pending config write holds off the input stream
//  - work per item: a clear, a dropped append or a text byte with no pattern
//    goes straight to the hand-over state; an append takes three 32 bit and
//    one 8 bit pass of the bit-serial modular multiplier; a text byte two 32
//    bit and one 8 bit pass, one more 8 bit pass once the window is full, plus
//    the byte walk of an m byte pattern when the hashes agree
//  - one item is in work at a time; the next beat is taken as soon as the
//    result sits in the output register, even if the receiver has not taken it
//  - a stalled receiver holds the result; a finished item then waits until the
//    output register frees up
//  - reset: base 256, modulus 1000000007, empty pattern, zero statistics;
//    memory contents are left undefined and never read before written
module rabin_karp_matcher (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [0:0]                  cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [7:0]                  s_axis_tdata_i,  // [7:0] data_byte
  input  logic [1:0]                  s_axis_tuser_i,  // [1:0] action
  // result stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  // [0] match_found, [1] false_positive, [33:2] match_position,
  // [34] pattern_overflow, [66:35] match_count, [98:67] false_positive_count,
  // [130:99] window_count, [135:131] zero
  output logic [rkm_pkg::OutW-1:0]    m_axis_tdata_o
);

  localparam int unsigned AW = rkm_pkg::AddrW;
  localparam int unsigned LW = rkm_pkg::LenW;
  localparam int unsigned HW = rkm_pkg::HashW;
  localparam int unsigned WW = rkm_pkg::WordW;

  // sequencer codes
  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StBase = 4'd1;   // reduce base mod m
  localparam logic [3:0] StPh1  = 4'd2;   // pattern hash * base
  localparam logic [3:0] StPh2  = 4'd3;   // byte mod m, add
  localparam logic [3:0] StBpw  = 4'd4;   // base power * base
  localparam logic [3:0] StWh1  = 4'd5;   // window hash * base
  localparam logic [3:0] StWh2  = 4'd6;   // byte mod m, add
  localparam logic [3:0] StOrd  = 4'd7;   // outgoing byte read back
  localparam logic [3:0] StSub  = 4'd8;   // outgoing byte * base power
  localparam logic [3:0] StUpd  = 4'd9;   // commit window, check hash
  localparam logic [3:0] StCmp  = 4'd10;  // byte-wise walk
  localparam logic [3:0] StFin  = 4'd11;  // hand result to output register

  logic [3:0]       state_q;
  logic [WW-1:0]    base_q, modulus_q, mod_eff;
  logic [LW-1:0]    plen_q;
  logic [HW-1:0]    phash_q, bpow_q, whash_q, base_r_q, h_q;
  logic [WW-1:0]    tpos_q;
  logic [AW-1:0]    head_q, widx_q;
  logic [LW-1:0]    iss_q;
  logic             rdv_q, mism_q;
  logic [WW-1:0]    mcnt_q, fcnt_q, wcnt_q;
  logic [1:0]       act_q;
  logic [7:0]       byte_q;
  logic             found_q, fp_q, ovf_q;
  logic [WW-1:0]    pos_q;
  logic             out_vld_q;
  logic [rkm_pkg::OutW-1:0] out_data_q;

  rkm_pkg::mm_req_t mm_req_q;
  rkm_pkg::mm_rsp_t mm_rsp;
  logic             mm_start;

  // memories
  logic [7:0]       pat_mem [rkm_pkg::MaxPattern];
  logic [7:0]       win_mem [rkm_pkg::MaxPattern];
  logic [7:0]       pat_rd_q, win_rd_q;
  logic             pat_we, pat_re, win_we, win_re;
  logic [AW-1:0]    pat_wa, pat_ra, win_wa, win_ra;

  logic             in_acc, cfg_acc, out_free, win_full, issuing;
  logic [WW-1:0]    tpos_inc;
  logic [AW-1:0]    head_nxt, widx_nxt;

  // modulus clamped to [2, 2^31]
  always_comb begin
    mod_eff = modulus_q;
    if (modulus_q < rkm_pkg::ModMin) mod_eff = rkm_pkg::ModMin;
    if (modulus_q > rkm_pkg::ModMax) mod_eff = rkm_pkg::ModMax;
  end

  // a config write wins over an input beat in the same cycle
  assign s_axis_tready_o = (state_q == StIdle) && !cfg_valid_i;
  assign cfg_ready_o     = (state_q == StIdle);
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_acc  = cfg_valid_i && cfg_ready_o;
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign win_full = (tpos_q >= {{(WW-LW){1'b0}}, plen_q});
  assign tpos_inc = rkm_pkg::sat_inc(tpos_q);
  assign issuing  = (state_q == StCmp) && (iss_q < plen_q);

  // circular window pointers wrap at the pattern length
  assign head_nxt = ({1'b0, head_q} + LW'(1) == plen_q) ? '0 : head_q + AW'(1);
  assign widx_nxt = ({1'b0, widx_q} + LW'(1) == plen_q) ? '0 : widx_q + AW'(1);

  // multiplier launch: on item start, after a finished pass that another pass
  // follows, and for the outgoing byte
  assign mm_start = ((state_q == StIdle) && in_acc
                     && (pat_we || ((s_axis_tuser_i == rkm_pkg::ActText)
                                    && (plen_q != '0))))
                    || (((state_q == StBase) || (state_q == StPh1) || (state_q == StWh1)
                         || (state_q == StPh2)) && mm_rsp.done)
                    || (state_q == StOrd);

  // memory port control
  always_comb begin
    pat_we = in_acc && (s_axis_tuser_i == rkm_pkg::ActAppend)
             && (plen_q < LW'(rkm_pkg::MaxPattern));
    pat_wa = plen_q[AW-1:0];
    pat_re = issuing;
    pat_ra = iss_q[AW-1:0];
    win_we = 1'b0;
    win_wa = head_q;
    win_re = 1'b0;
    win_ra = head_q;
    if (state_q == StWh2 && mm_rsp.done) begin
      if (win_full) begin
        win_re = 1'b1;          // fetch the outgoing byte first
      end else begin
        win_we = 1'b1;
        win_wa = tpos_q[AW-1:0];
      end
    end
    if (state_q == StOrd) win_we = 1'b1;  // new byte replaces the oldest
    if (issuing) begin
      win_re = 1'b1;
      win_ra = widx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pat_we) pat_mem[pat_wa] <= s_axis_tdata_i;
    if (pat_re) pat_rd_q <= pat_mem[pat_ra];
  end

  always_ff @(posedge clk_i) begin
    if (win_we) win_mem[win_wa] <= byte_q;
    if (win_re) win_rd_q <= win_mem[win_ra];
  end

  rkm_modmul u_modmul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .modulus_i (mod_eff),
    .req_i     (mm_req_q),
    .rsp_o     (mm_rsp)
  );

  // sequencer and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      base_q    <= 32'd256;
      modulus_q <= 32'd1000000007;
      plen_q    <= '0;
      phash_q   <= '0;
      bpow_q    <= HW'(1);
      whash_q   <= '0;
      tpos_q    <= '0;
      head_q    <= '0;
      widx_q    <= '0;
      iss_q     <= '0;
      rdv_q     <= 1'b0;
      mism_q    <= 1'b0;
      mcnt_q    <= '0;
      fcnt_q    <= '0;
      wcnt_q    <= '0;
      mm_req_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mm_req_q.start <= mm_start;
      // in the hand-over state the output register is reloaded instead
      if (m_axis_tready_i && (state_q != StFin)) out_vld_q <= 1'b0;

      unique case (state_q)
        StIdle: begin
          if (cfg_acc) begin
            if (cfg_index_i == rkm_pkg::RegBase) base_q    <= cfg_data_i;
            else                                 modulus_q <= cfg_data_i;
            plen_q  <= '0;
            phash_q <= '0;
            bpow_q  <= HW'(1);
            whash_q <= '0;
            tpos_q  <= '0;
            head_q  <= '0;
          end else if (in_acc) begin
            case (s_axis_tuser_i)
              rkm_pkg::ActClearPat: begin
                plen_q  <= '0;
                phash_q <= '0;
                bpow_q  <= HW'(1);
                whash_q <= '0;
                tpos_q  <= '0;
                head_q  <= '0;
                state_q <= StFin;
              end
              rkm_pkg::ActClearStats: begin
                mcnt_q  <= '0;
                fcnt_q  <= '0;
                wcnt_q  <= '0;
                state_q <= StFin;
              end
              default: begin
                // append with room left, or text with a pattern present
                if ((s_axis_tuser_i == rkm_pkg::ActAppend && pat_we)
                    || (s_axis_tuser_i == rkm_pkg::ActText && plen_q != '0)) begin
                  mm_req_q.short_op <= 1'b0;
                  mm_req_q.a        <= HW'(1);
                  mm_req_q.q        <= base_q;
                  state_q           <= StBase;
                end else begin
                  state_q <= StFin;
                end
              end
            endcase
          end
        end
        StBase: begin
          if (mm_rsp.done) begin
            base_r_q          <= mm_rsp.res;
            mm_req_q.short_op <= 1'b0;
            mm_req_q.q        <= {1'b0, mm_rsp.res};
            if (act_q == rkm_pkg::ActAppend) begin
              mm_req_q.a <= phash_q;
              state_q    <= StPh1;
            end else begin
              mm_req_q.a <= whash_q;
              state_q    <= StWh1;
            end
          end
        end
        StPh1, StWh1: begin
          if (mm_rsp.done) begin
            h_q               <= mm_rsp.res;
            mm_req_q.short_op <= 1'b1;
            mm_req_q.a        <= HW'(1);
            mm_req_q.q        <= {24'd0, byte_q};
            state_q           <= (state_q == StPh1) ? StPh2 : StWh2;
          end
        end
        StPh2: begin
          if (mm_rsp.done) begin
            phash_q           <= rkm_pkg::add_mod(h_q, mm_rsp.res, mod_eff);
            mm_req_q.short_op <= 1'b0;
            mm_req_q.a        <= bpow_q;
            mm_req_q.q        <= {1'b0, base_r_q};
            state_q           <= StBpw;
          end
        end
        StBpw: begin
          if (mm_rsp.done) begin
            bpow_q  <= mm_rsp.res;
            plen_q  <= plen_q + LW'(1);
            whash_q <= '0;
            tpos_q  <= '0;
            head_q  <= '0;
            state_q <= StFin;
          end
        end
        StWh2: begin
          if (mm_rsp.done) begin
            h_q     <= rkm_pkg::add_mod(h_q, mm_rsp.res, mod_eff);
            state_q <= win_full ? StOrd : StUpd;
          end
        end
        StOrd: begin
          mm_req_q.short_op <= 1'b1;
          mm_req_q.a        <= bpow_q;
          mm_req_q.q        <= {24'd0, win_rd_q};
          state_q           <= StSub;
        end
        StSub: begin
          if (mm_rsp.done) begin
            h_q     <= rkm_pkg::sub_mod(h_q, mm_rsp.res, mod_eff);
            head_q  <= head_nxt;
            state_q <= StUpd;
          end
        end
        StUpd: begin
          whash_q <= h_q;
          tpos_q  <= tpos_inc;
          if (tpos_inc >= {{(WW-LW){1'b0}}, plen_q}) begin
            wcnt_q <= rkm_pkg::sat_inc(wcnt_q);
            if (h_q == phash_q) begin
              iss_q   <= '0;
              widx_q  <= head_q;
              rdv_q   <= 1'b0;
              mism_q  <= 1'b0;
              state_q <= StCmp;
            end else begin
              state_q <= StFin;
            end
          end else begin
            state_q <= StFin;
          end
        end
        StCmp: begin
          // reads issued one cycle, compared the next
          rdv_q <= issuing;
          if (issuing) begin
            iss_q  <= iss_q + LW'(1);
            widx_q <= widx_nxt;
          end
          if (rdv_q && (pat_rd_q != win_rd_q)) mism_q <= 1'b1;
          if (!issuing && !rdv_q) begin
            if (mism_q) fcnt_q <= rkm_pkg::sat_inc(fcnt_q);
            else        mcnt_q <= rkm_pkg::sat_inc(mcnt_q);
            state_q <= StFin;
          end
        end
        StFin: begin
          if (out_free) begin
            out_vld_q <= 1'b1;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // per-item result fields
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= s_axis_tuser_i;
      byte_q  <= s_axis_tdata_i;
      found_q <= 1'b0;
      fp_q    <= 1'b0;
      pos_q   <= '0;
      ovf_q   <= (s_axis_tuser_i == rkm_pkg::ActAppend) && !pat_we;
    end
    if (state_q == StUpd && tpos_inc >= {{(WW-LW){1'b0}}, plen_q}) begin
      pos_q <= tpos_inc - {{(WW-LW){1'b0}}, plen_q};
    end
    if (state_q == StCmp && !issuing && !rdv_q) begin
      found_q <= !mism_q;
      fp_q    <= mism_q;
    end
    if (state_q == StFin && out_free) begin
      out_data_q <= {5'd0, wcnt_q, fcnt_q, mcnt_q, ovf_q, pos_q, fp_q, found_q};
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

>>> design/rkm_checker.sv
// rkm_checker: port-level checks of the rabin-karp matcher, bound to the top level
// depends on rkm_pkg and rabin_karp_matcher
module rkm_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      m_axis_tvalid_o,
  input logic                      m_axis_tready_i,
  input logic [rkm_pkg::OutW-1:0]  m_axis_tdata_o
);

  // a result beat waiting for the receiver stays as it is
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result beat changed while stalled");

  // match and false positive never together
  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("match and false positive both set");

  // a dropped pattern byte is no text result
  a_ovf_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[34] |-> !m_axis_tdata_o[0] && !m_axis_tdata_o[1])
    else $error("overflow beat carries a text flag");

  // a confirmed match is counted
  a_match_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[66:35] != 32'd0)
    else $error("match without count");

endmodule

bind rabin_karp_matcher rkm_checker u_rkm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
